>>> rtl/sfcfm_pkg.sv
// shared constants, codes and helper functions of the sensor frame crc filter unit
package sfcfm_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int FRAC_BITS   = 8;
	localparam int DATA_BYTES  = FRAME_BYTES - 2;
	localparam int CNT_W       = $clog2(FRAME_BYTES);

	// bytes 2..5 carry the humidity and the temperature
	localparam int VAL_FIRST = 2;
	localparam int VAL_BYTES = 4;
	localparam int VAL_IDX_W = $clog2(VAL_BYTES);

	localparam int TEMP_W  = 16 + FRAC_BITS;
	localparam int HUM_W   = 17 + FRAC_BITS;
	localparam int ALPHA_W = 9;
	localparam int OUT_W   = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(77);
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
	localparam int                 ALPHA_SHIFT = 8;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int ROUND_ADJ = (1 << FRAC_BITS) - 1;

	typedef enum logic [0:0] {
		OP_BYTE      = 1'b0,
		OP_MINMAX_RST = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		ST_GOOD    = 1'b0,
		ST_CRC_ERR = 1'b1
	} status_t;

	// one byte of the reflected modbus crc
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// signed fixed point to whole tenths, truncated toward zero
	function automatic logic [OUT_W-1:0] temp_tenths(input logic signed [TEMP_W-1:0] v);
		logic signed [TEMP_W-1:0] adj;
		adj = v[TEMP_W-1] ? v + signed'(TEMP_W'(ROUND_ADJ)) : v;
		return OUT_W'(adj >>> FRAC_BITS);
	endfunction

	function automatic logic [OUT_W-1:0] hum_tenths(input logic signed [HUM_W-1:0] v);
		return OUT_W'(v >> FRAC_BITS);
	endfunction

endpackage

>>> rtl/sensor_frame_crc_filter_minmax_unit.sv
// top level: sensor reply frame crc check, low-pass filter and min/max tracking
//
//   channel | signals                               | role
//   --------+---------------------------------------+--------------------------------
//   in      | in_valid, in_ready, opcode,           | one frame byte or a min/max
//           | data_byte, first_byte                 | reset command per transfer
//   out     | out_valid, out_ready, status, temp.., | one result after the last byte
//           | humidity, temp_min/max, hum_min/max   | of each frame
//   cfg     | cfg_we, cfg_wdata                     | filter_alpha write, no wait
//
// one item per cycle while no result stalls on a full output; an item waits in
// the input register, where crc, filter multiply and min/max compare finish,
// and its result is then registered in the output register
// arst_n clears control and tracking state; crc starts at 0xffff, alpha at 77
// a stalled result only holds back the input register when the next item there
// also closes a frame; bytes that produce no result keep flowing
module sensor_frame_crc_filter_minmax_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic [15:0]                       temperature,
	output logic [15:0]                       humidity,
	output logic [15:0]                       temp_min,
	output logic [15:0]                       temp_max,
	output logic [15:0]                       hum_min,
	output logic [15:0]                       hum_max,
	input  logic                              cfg_we,
	input  logic [sfcfm_pkg::ALPHA_W-1:0]     cfg_wdata
);
	import sfcfm_pkg::*;

	// input register
	logic             valid_s1;
	logic             opcode_s1;
	logic [7:0]       data_s1;
	logic             first_s1;

	// block state
	logic [ALPHA_W-1:0]      alpha_q;
	logic [CNT_W-1:0]        count_q;
	logic [15:0]             crc_q;
	logic [7:0]              val_q [VAL_BYTES];
	logic                    have_value_q;
	logic signed [TEMP_W-1:0] ft_q, tlo_q, thi_q;
	logic signed [HUM_W-1:0]  fh_q, hlo_q, hhi_q;
	logic                    out_valid_q;

	// stage logic
	logic             is_byte, is_mm;
	logic [CNT_W-1:0] pos, pos_next;
	logic [15:0]      crc_base, crc_next;
	logic             makes_res, go_s1, fire_s1, res_fire, good;
	logic             store_val;
	logic [VAL_IDX_W-1:0] val_idx;

	logic [14:0]              t_mag;
	logic signed [TEMP_W-1:0] t_mag_f, tx;
	logic signed [HUM_W-1:0]  hx;
	logic [ALPHA_W-1:0]       alpha_sat;
	logic signed [ALPHA_W:0]  alpha_s;
	logic signed [TEMP_W:0]   dt;
	logic signed [HUM_W:0]    dh;
	logic signed [TEMP_W+ALPHA_W+1:0] prod_t;
	logic signed [HUM_W+ALPHA_W+1:0]  prod_h;
	logic signed [TEMP_W-1:0] nft, ntlo, nthi;
	logic signed [HUM_W-1:0]  nfh, nhlo, nhhi;

	assign is_byte = (opcode_s1 == OP_BYTE);
	assign is_mm   = (opcode_s1 == OP_MINMAX_RST);

	// frame position and crc, restarted by the first-byte mark
	assign pos      = first_s1 ? '0 : count_q;
	assign crc_base = first_s1 ? CRC_INIT : crc_q;

	always_comb begin
		if (pos < CNT_W'(DATA_BYTES)) begin
			crc_next = crc_byte(crc_base, data_s1);
		end else if (pos == CNT_W'(DATA_BYTES)) begin
			// received crc low byte folds in; a match leaves it zero
			crc_next = crc_base ^ {8'h00, data_s1};
		end else begin
			crc_next = CRC_INIT;
		end
	end

	assign pos_next  = (pos == CNT_W'(FRAME_BYTES - 1)) ? '0 : pos + CNT_W'(1);
	assign makes_res = is_byte && (pos == CNT_W'(FRAME_BYTES - 1));
	assign good      = (crc_base[7:0] == 8'h00) && (crc_base[15:8] == data_s1);

	// bytes 2..5 are kept for decoding
	assign store_val = (pos >= CNT_W'(VAL_FIRST)) && (pos < CNT_W'(VAL_FIRST + VAL_BYTES));
	assign val_idx   = VAL_IDX_W'(pos - CNT_W'(VAL_FIRST));

	// handshake: stall only when a result is due and the output is still full
	assign go_s1    = !makes_res || !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && go_s1;
	assign in_ready = !valid_s1 || go_s1;
	assign res_fire = fire_s1 && makes_res;

	// decode: humidity unsigned in bytes 2..3, temperature sign-magnitude in 4..5
	assign hx      = HUM_W'({val_q[0], val_q[1]}) << FRAC_BITS;
	assign t_mag   = {val_q[2][6:0], val_q[3]};
	assign t_mag_f = TEMP_W'(t_mag) << FRAC_BITS;
	assign tx      = val_q[2][7] ? -t_mag_f : t_mag_f;

	// low-pass step, floor division by 256 via arithmetic shift
	assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_s   = signed'({1'b0, alpha_sat});
	assign dt        = {tx[TEMP_W-1], tx} - {ft_q[TEMP_W-1], ft_q};
	assign dh        = {hx[HUM_W-1], hx} - {fh_q[HUM_W-1], fh_q};
	assign prod_t    = dt * alpha_s;
	assign prod_h    = dh * alpha_s;

	always_comb begin
		if (!have_value_q) begin
			// first good frame loads everything with the sample
			nft  = tx;
			nfh  = hx;
			ntlo = tx;
			nthi = tx;
			nhlo = hx;
			nhhi = hx;
		end else begin
			nft  = ft_q + TEMP_W'(prod_t >>> ALPHA_SHIFT);
			nfh  = fh_q + HUM_W'(prod_h >>> ALPHA_SHIFT);
			ntlo = (nft < tlo_q) ? nft : tlo_q;
			nthi = (nft > thi_q) ? nft : thi_q;
			nhlo = (nfh < hlo_q) ? nfh : hlo_q;
			nhhi = (nfh > hhi_q) ? nfh : hhi_q;
		end
		// bad crc changes nothing
		if (!good) begin
			nft  = ft_q;
			nfh  = fh_q;
			ntlo = tlo_q;
			nthi = thi_q;
			nhlo = hlo_q;
			nhhi = hhi_q;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			data_s1   <= data_byte;
			first_s1  <= first_byte;
		end
	end

	// frame bytes, no reset
	always_ff @(posedge clk) begin
		if (fire_s1 && is_byte && store_val) begin
			val_q[val_idx] <= data_s1;
		end
	end

	// frame tracking and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			crc_q        <= CRC_INIT;
			have_value_q <= 1'b0;
			ft_q         <= '0;
			fh_q         <= '0;
			tlo_q        <= '0;
			thi_q        <= '0;
			hlo_q        <= '0;
			hhi_q        <= '0;
		end else if (fire_s1) begin
			if (is_mm) begin
				tlo_q <= ft_q;
				thi_q <= ft_q;
				hlo_q <= fh_q;
				hhi_q <= fh_q;
			end else begin
				count_q <= pos_next;
				crc_q   <= crc_next;
				if (makes_res && good) begin
					have_value_q <= 1'b1;
					ft_q         <= nft;
					fh_q         <= nfh;
					tlo_q        <= ntlo;
					thi_q        <= nthi;
					hlo_q        <= nhlo;
					hhi_q        <= nhhi;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status      <= good ? ST_GOOD : ST_CRC_ERR;
			temperature <= temp_tenths(nft);
			humidity    <= hum_tenths(nfh);
			temp_min    <= temp_tenths(ntlo);
			temp_max    <= temp_tenths(nthi);
			hum_min     <= hum_tenths(nhlo);
			hum_max     <= hum_tenths(nhhi);
		end
	end

	assign out_valid = out_valid_q;

	// once a good frame has been seen the filter never drops back to load mode
	a_have_value_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		have_value_q |=> have_value_q)
		else $error("have_value cleared after a good frame");

	// a frame-closing byte leaving the input register always shows a result next
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> out_valid)
		else $error("result lost after last frame byte");

	// filtered temperature stays within its tracked extremes
	a_temp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(temp_min) <= $signed(temperature)) &&
			($signed(temperature) <= $signed(temp_max)))
		else $error("temperature outside min/max");

	// filtered humidity stays within its tracked extremes
	a_hum_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hum_min <= humidity) && (humidity <= hum_max))
		else $error("humidity outside min/max");

endmodule

>>> bench/tb_top.sv
// self-checking bench for the sensor frame crc check, low-pass filter and min/max unit
`timescale 1ns / 100ps

module tb_top;
	import sfcfm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 135;

	// one result transfer as seen on the output channel
	typedef struct packed {
		status_t     status;
		logic [15:0] temperature;
		logic [15:0] humidity;
		logic [15:0] temp_min;
		logic [15:0] temp_max;
		logic [15:0] hum_min;
		logic [15:0] hum_max;
	} reading_t;

	// ways a frame is sent
	typedef enum int {
		FRAME_CLEAN,
		FRAME_BAD_DATA,
		FRAME_BAD_CRC,
		FRAME_MID_RESET
	} frame_kind_t;

	// mirror of the unit: crc, decode, filter and min/max, plus the queue of due readings
	class reading_board;
		bit [ALPHA_W-1:0] alpha;
		int unsigned      byte_pos;
		bit [15:0]        crc;
		bit [7:0]         body [DATA_BYTES];
		bit               have_value;
		longint           temp_now, hum_now;
		longint           temp_lo, temp_hi, hum_lo, hum_hi;
		reading_t         due_readings [$];
		int               errors;

		function new();
			alpha      = ALPHA_RESET;
			byte_pos   = 0;
			crc        = CRC_INIT;
			have_value = 1'b0;
			temp_now   = 0;
			hum_now    = 0;
			temp_lo    = 0;
			temp_hi    = 0;
			hum_lo     = 0;
			hum_hi     = 0;
			errors     = 0;
			foreach (body[i]) body[i] = 8'h00;
		endfunction

		static function bit [15:0] crc_fold(bit [15:0] c, bit [7:0] b);
			c = c ^ {8'h00, b};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			return c;
		endfunction

		// alpha step, floor division by 256 through an arithmetic shift
		static function longint smooth(longint old, longint x, longint a);
			longint d;
			d = a * (x - old);
			return old + (d >>> ALPHA_SHIFT);
		endfunction

		static function bit [15:0] tenths(longint v);
			longint t;
			t = (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
			return t[15:0];
		endfunction

		function void set_alpha(bit [ALPHA_W-1:0] a);
			alpha = a;
		endfunction

		function int outstanding();
			return due_readings.size();
		endfunction

		function void note_transfer(op_t op, bit [7:0] b, bit first);
			bit       good;
			longint   a, mag, tx, hx;
			reading_t r;
			if (op == OP_MINMAX_RST) begin
				temp_lo = temp_now;
				temp_hi = temp_now;
				hum_lo  = hum_now;
				hum_hi  = hum_now;
				return;
			end
			if (first) begin
				byte_pos = 0;
				crc      = CRC_INIT;
			end
			if (byte_pos < DATA_BYTES) begin
				body[byte_pos] = b;
				crc            = crc_fold(crc, b);
				byte_pos++;
				return;
			end
			if (byte_pos == DATA_BYTES) begin
				// received crc low byte folds straight into the accumulator
				crc = crc ^ {8'h00, b};
				byte_pos++;
				return;
			end
			good     = (crc[7:0] == 8'h00) && (crc[15:8] == b);
			byte_pos = 0;
			crc      = CRC_INIT;
			if (good) begin
				a   = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
				mag = {body[4][6:0], body[5]};
				tx  = body[4][7] ? -mag : mag;
				hx  = {body[2], body[3]};
				tx  = tx <<< FRAC_BITS;
				hx  = hx <<< FRAC_BITS;
				if (!have_value) begin
					temp_now   = tx;
					hum_now    = hx;
					temp_lo    = tx;
					temp_hi    = tx;
					hum_lo     = hx;
					hum_hi     = hx;
					have_value = 1'b1;
				end else begin
					temp_now = smooth(temp_now, tx, a);
					hum_now  = smooth(hum_now, hx, a);
				end
				if (temp_now > temp_hi) temp_hi = temp_now;
				if (temp_now < temp_lo) temp_lo = temp_now;
				if (hum_now > hum_hi) hum_hi = hum_now;
				if (hum_now < hum_lo) hum_lo = hum_now;
			end
			r.status      = good ? ST_GOOD : ST_CRC_ERR;
			r.temperature = tenths(temp_now);
			r.humidity    = tenths(hum_now);
			r.temp_min    = tenths(temp_lo);
			r.temp_max    = tenths(temp_hi);
			r.hum_min     = tenths(hum_lo);
			r.hum_max     = tenths(hum_hi);
			due_readings.push_back(r);
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			bit       bad;
			if (due_readings.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer: status %0d temp %0d hum %0d",
						got.status, $signed(got.temperature), got.humidity);
				return;
			end
			want = due_readings.pop_front();
			bad  = (got.status != want.status) || (got.temperature != want.temperature)
				|| (got.humidity != want.humidity) || (got.temp_min != want.temp_min)
				|| (got.temp_max != want.temp_max) || (got.hum_min != want.hum_min)
				|| (got.hum_max != want.hum_max);
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("reading mismatch, expected st %0d t %0d h %0d tmin %0d tmax %0d hmin %0d hmax %0d",
						want.status, $signed(want.temperature), want.humidity,
						$signed(want.temp_min), $signed(want.temp_max), want.hum_min, want.hum_max);
					$display("                  actual   st %0d t %0d h %0d tmin %0d tmax %0d hmin %0d hmax %0d",
						got.status, $signed(got.temperature), got.humidity,
						$signed(got.temp_min), $signed(got.temp_max), got.hum_min, got.hum_max);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic                opcode     = OP_BYTE;
	logic [7:0]          data_byte  = 8'h00;
	logic                first_byte = 1'b0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic                status;
	logic [15:0]         temperature, humidity, temp_min, temp_max, hum_min, hum_max;
	logic                cfg_we     = 1'b0;
	logic [ALPHA_W-1:0]  cfg_wdata  = '0;

	reading_board board = new();

	// idling knobs, changed per phase; calm switches all idling off
	bit send_gaps  = 1'b0;
	bit recv_stall = 1'b0;
	bit calm       = 1'b0;
	int stall_left = 0;
	int items_sent = 0;
	int cycles     = 0;

	sensor_frame_crc_filter_minmax_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.temperature (temperature),
		.humidity    (humidity),
		.temp_min    (temp_min),
		.temp_max    (temp_max),
		.hum_min     (hum_min),
		.hum_max     (hum_max),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: the run must be over well before this many cycles
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sensor_frame_crc_filter_minmax_unit test failed");
		$finish;
	end

	// output side: check a result transfer, then pick the next ready level
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_reading({status_t'(status), temperature, humidity,
				temp_min, temp_max, hum_min, hum_max});
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!calm && recv_stall && $urandom_range(0, 4) == 0) begin
			out_ready  <= 1'b0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one input transfer; the predictor sees it at the edge that accepts it
	task automatic put_item(input op_t op, input bit [7:0] b, input bit first);
		if (!calm && send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		data_byte  <= b;
		first_byte <= first;
		do @(posedge clk); while (!in_ready);
		board.note_transfer(op, b, first);
		items_sent++;
	endtask

	// full frame with its crc appended, low byte first, optionally damaged
	task automatic send_frame(input bit [47:0] payload, input frame_kind_t kind, input bit mark);
		bit [7:0]  fb [FRAME_BYTES];
		bit [15:0] c;
		int        k;
		c = CRC_INIT;
		for (int i = 0; i < DATA_BYTES; i++) begin
			fb[i] = payload[47 - 8 * i -: 8];
			c     = reading_board::crc_fold(c, fb[i]);
		end
		fb[6] = c[7:0];
		fb[7] = c[15:8];
		k     = $urandom_range(0, FRAME_BYTES - 1);
		if (kind == FRAME_BAD_DATA)
			fb[k % DATA_BYTES] ^= 8'($urandom_range(1, 255));
		if (kind == FRAME_BAD_CRC)
			fb[DATA_BYTES + (k % 2)] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < FRAME_BYTES; i++) begin
			// a min/max reset before or between bytes must not disturb the byte count
			if (kind == FRAME_MID_RESET && i == k)
				put_item(OP_MINMAX_RST, 8'($urandom), 1'($urandom));
			put_item(OP_BYTE, fb[i], (i == 0) ? mark : 1'b0);
		end
	endtask

	function automatic bit [47:0] random_payload();
		bit [15:0] hum, temp;
		case ($urandom_range(0, 5))
			0:       hum = 16'h0000;
			1:       hum = 16'hFFFF;
			2, 3:    hum = 16'($urandom_range(200, 900));
			default: hum = 16'($urandom);
		endcase
		case ($urandom_range(0, 6))
			0:       temp = 16'h8000;  // negative zero
			1:       temp = 16'hFFFF;
			2:       temp = 16'h7FFF;
			3, 4:    temp = {1'($urandom), 15'($urandom_range(0, 400))};
			default: temp = 16'($urandom);
		endcase
		return {8'($urandom), 8'($urandom), hum, temp};
	endfunction

	// hold off until every due reading is in, then let the pipe run dry
	task automatic wait_drained();
		while (board.outstanding() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_alpha(input bit [ALPHA_W-1:0] a);
		cfg_we    <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_alpha(a);
	endtask

	// a mix of mostly well-formed frames with some damage and noise
	task automatic random_traffic(input int budget);
		int          r, n;
		bit          mark;
		frame_kind_t kind;
		while (items_sent < budget) begin
			r    = $urandom_range(0, 99);
			mark = (board.byte_pos != 0) || ($urandom_range(0, 3) != 0);
			if (r < 90) begin
				if (r < 68)      kind = FRAME_CLEAN;
				else if (r < 76) kind = FRAME_BAD_DATA;
				else if (r < 83) kind = FRAME_BAD_CRC;
				else             kind = FRAME_MID_RESET;
				send_frame(random_payload(), kind, mark);
			end else if (r < 95) begin
				put_item(OP_MINMAX_RST, 8'($urandom), 1'($urandom));
			end else begin
				// broken prefix, may restart mid-way through first_byte
				n = $urandom_range(1, 7);
				for (int i = 0; i < n; i++)
					put_item(OP_BYTE, 8'($urandom), ($urandom_range(0, 2) == 0));
			end
		end
	endtask

	initial begin
		bit [ALPHA_W-1:0] alpha_plan [PHASES];
		alpha_plan[0] = ALPHA_RESET;
		alpha_plan[1] = '0;
		alpha_plan[2] = ALPHA_ONE;
		alpha_plan[3] = '1;
		alpha_plan[4] = ALPHA_W'(1);
		alpha_plan[5] = ALPHA_W'($urandom_range(257, 510));
		alpha_plan[6] = ALPHA_W'($urandom_range(2, 255));
		alpha_plan[7] = ALPHA_W'($urandom_range(0, 511));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: min/max reset before any reading, a bad crc, extremes, negative zero
		put_item(OP_MINMAX_RST, 8'hFF, 1'b1);
		send_frame(48'hFFFF_FFFF_FFFF, FRAME_BAD_CRC, 1'b1);
		send_frame(48'h0304_FFFF_FFFF, FRAME_CLEAN, 1'b1);
		send_frame(48'h0000_0000_8000, FRAME_CLEAN, 1'b0);
		in_valid <= 1'b0;
		wait_drained();

		// phases at different alpha settings; the sender pauses for a full drain each time
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0)
				write_alpha(alpha_plan[p]);
			calm       = (p == PHASES - 1);
			send_gaps  = ($urandom_range(0, 3) != 0);
			recv_stall = ($urandom_range(0, 3) != 0);
			random_traffic(items_sent + PHASE_ITEMS);
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("sensor_frame_crc_filter_minmax_unit test passed");
		end else begin
			$display("sensor_frame_crc_filter_minmax_unit test failed");
		end
		$finish;
	end

endmodule
